@@ rtl/spq_pkg.sv @@
package spq_pkg;

  localparam int QueueDepth = 16;
  localparam int CountW     = $clog2(QueueDepth + 1);
  localparam int PrioW      = 4;
  localparam int TagW       = 16;
  localparam int StatusW    = 2;
  localparam int OccW       = 5;

  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [PrioW-1:0] prio;
  } entry_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_POP    = 1'b1
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_INSERTED = 2'd0,
    ST_POPPED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_POP,
    OP_REJECT_FULL,
    OP_REJECT_EMPTY
  } op_e;

  typedef enum logic {
    CS_IDLE,
    CS_HOLD
  } ctrl_state_e;

  typedef struct packed {
    op_e op;
  } dp_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dp_status_t;

endpackage

@@ rtl/spq_if.sv @@
interface spq_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [spq_pkg::PrioW-1:0]    prio;
  logic [spq_pkg::TagW-1:0]     tag;

  modport source (output valid, output cmd, output prio, output tag, input ready);
  modport sink   (input valid, input cmd, input prio, input tag, output ready);
endinterface

interface spq_out_if;
  logic                         valid;
  logic                         ready;
  logic [spq_pkg::StatusW-1:0]  status;
  logic [spq_pkg::TagW-1:0]     out_tag;
  logic [spq_pkg::PrioW-1:0]    out_prio;
  logic [spq_pkg::OccW-1:0]     occupancy;

  modport source (output valid, output status, output out_tag, output out_prio,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input out_tag, input out_prio,
                  input occupancy, output ready);
endinterface

@@ rtl/spq_ctrl.sv @@
module spq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 cmd_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  spq_pkg::dp_status_t  dp_status_i,
  output spq_pkg::dp_ctl_t     dp_ctl_o
);

  spq_pkg::ctrl_state_e state_q, state_d;
  logic                 fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spq_pkg::CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    in_ready_o  = (state_q == spq_pkg::CS_IDLE) || out_ready_i;
    out_valid_o = (state_q == spq_pkg::CS_HOLD);
    fire        = in_valid_i && in_ready_o;
    dp_ctl_o.op = spq_pkg::OP_NONE;
    if (fire) begin
      if (cmd_i == spq_pkg::CMD_INSERT) begin
        dp_ctl_o.op = dp_status_i.full ? spq_pkg::OP_REJECT_FULL : spq_pkg::OP_INSERT;
      end else begin
        dp_ctl_o.op = dp_status_i.empty ? spq_pkg::OP_REJECT_EMPTY : spq_pkg::OP_POP;
      end
    end
    state_d = state_q;
    unique case (state_q)
      spq_pkg::CS_IDLE: begin
        if (fire) state_d = spq_pkg::CS_HOLD;
      end
      spq_pkg::CS_HOLD: begin
        if (out_ready_i && !fire) state_d = spq_pkg::CS_IDLE;
      end
      default: state_d = spq_pkg::CS_IDLE;
    endcase
  end

endmodule

@@ rtl/spq_datapath.sv @@
module spq_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  spq_pkg::dp_ctl_t              dp_ctl_i,
  output spq_pkg::dp_status_t           dp_status_o,
  input  logic [spq_pkg::PrioW-1:0]     prio_i,
  input  logic [spq_pkg::TagW-1:0]      tag_i,
  output logic [spq_pkg::StatusW-1:0]   status_o,
  output logic [spq_pkg::TagW-1:0]      out_tag_o,
  output logic [spq_pkg::PrioW-1:0]     out_prio_o,
  output logic [spq_pkg::OccW-1:0]      occupancy_o
);

  spq_pkg::entry_t                   slot_q [spq_pkg::QueueDepth];
  spq_pkg::entry_t                   slot_d [spq_pkg::QueueDepth];
  logic [spq_pkg::QueueDepth-1:0]    le;
  logic [spq_pkg::CountW-1:0]        count_q, count_d;
  spq_pkg::entry_t                   new_entry;
  logic                              shift_en;

  logic [spq_pkg::StatusW-1:0]       status_q, status_d;
  logic [spq_pkg::TagW-1:0]          tag_q, tag_d;
  logic [spq_pkg::PrioW-1:0]         prio_q, prio_d;
  logic [spq_pkg::OccW-1:0]          occ_q, occ_d;
  logic                              res_en;

  assign new_entry.tag  = tag_i;
  assign new_entry.prio = prio_i;

  // Every slot compares itself with the new priority; since the list is sorted,
  // the slots that stay in place form a prefix.
  for (genvar i = 0; i < spq_pkg::QueueDepth; i++) begin : g_slot
    assign le[i] = (spq_pkg::CountW'(i) < count_q) && (slot_q[i].prio <= prio_i);

    always_comb begin
      slot_d[i] = slot_q[i];
      if (dp_ctl_i.op == spq_pkg::OP_INSERT) begin
        if (!le[i]) begin
          if (i == 0) begin
            slot_d[i] = new_entry;
          end else if (le[(i == 0) ? 0 : i-1]) begin
            slot_d[i] = new_entry;
          end else begin
            slot_d[i] = slot_q[(i == 0) ? 0 : i-1];
          end
        end
      end else if (dp_ctl_i.op == spq_pkg::OP_POP) begin
        slot_d[i] = slot_q[(i == spq_pkg::QueueDepth-1) ? i : i+1];
      end
    end
  end

  assign shift_en = (dp_ctl_i.op == spq_pkg::OP_INSERT) || (dp_ctl_i.op == spq_pkg::OP_POP);
  assign res_en   = (dp_ctl_i.op != spq_pkg::OP_NONE);

  assign dp_status_o.full  = (count_q == spq_pkg::CountW'(spq_pkg::QueueDepth));
  assign dp_status_o.empty = (count_q == '0);

  always_comb begin
    count_d  = count_q;
    status_d = spq_pkg::ST_INSERTED;
    tag_d    = '0;
    prio_d   = '0;
    unique case (dp_ctl_i.op)
      spq_pkg::OP_INSERT: begin
        count_d  = count_q + spq_pkg::CountW'(1);
        status_d = spq_pkg::ST_INSERTED;
      end
      spq_pkg::OP_POP: begin
        count_d  = count_q - spq_pkg::CountW'(1);
        status_d = spq_pkg::ST_POPPED;
        tag_d    = slot_q[0].tag;
        prio_d   = slot_q[0].prio;
      end
      spq_pkg::OP_REJECT_FULL:  status_d = spq_pkg::ST_FULL;
      spq_pkg::OP_REJECT_EMPTY: status_d = spq_pkg::ST_EMPTY;
      default:                  status_d = spq_pkg::ST_INSERTED;
    endcase
    occ_d = spq_pkg::OccW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int i = 0; i < spq_pkg::QueueDepth; i++) begin
        slot_q[i] <= slot_d[i];
      end
    end
    if (res_en) begin
      status_q <= status_d;
      tag_q    <= tag_d;
      prio_q   <= prio_d;
      occ_q    <= occ_d;
    end
  end

  assign status_o    = status_q;
  assign out_tag_o   = tag_q;
  assign out_prio_o  = prio_q;
  assign occupancy_o = occ_q;

endmodule

@@ rtl/stable_priority_queue_top.sv @@
// Stable priority queue of up to 16 entries, each a 16-bit tag and a 4-bit
// priority. A lower priority number is served first; equal priorities leave
// in arrival order.
// The input channel in_i carries one item per access: cmd selects insert or
// pop, and prio and tag describe the inserted entry. The output channel out_o
// returns exactly one item per access with its status (inserted, popped, pop
// on empty, insert on full), the popped tag and priority, and the occupancy
// after the access.
// The entries sit in a chain of slot registers that all compare with the new
// priority at once and shift by one place, so the result item appears in the
// cycle after acceptance, and one item per cycle is sustained while the
// receiver keeps ready high.
// The result is held in an output register. While the receiver stalls, the
// block still accepts one new item in the cycle the held result is taken, and
// otherwise holds ready low.
// Reset empties the queue at once and clears any pending result.
module stable_priority_queue_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);

  spq_pkg::dp_ctl_t    dp_ctl;
  spq_pkg::dp_status_t dp_status;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .cmd_i       (in_i.cmd),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .dp_status_i (dp_status),
    .dp_ctl_o    (dp_ctl)
  );

  spq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dp_ctl_i    (dp_ctl),
    .dp_status_o (dp_status),
    .prio_i      (in_i.prio),
    .tag_i       (in_i.tag),
    .status_o    (out_o.status),
    .out_tag_o   (out_o.out_tag),
    .out_prio_o  (out_o.out_prio),
    .occupancy_o (out_o.occupancy)
  );

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> out_o.valid)
    else $error("accepted item produced no result");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == spq_pkg::ST_EMPTY) |->
    (out_o.occupancy == '0 && out_o.out_tag == '0 && out_o.out_prio == '0))
    else $error("pop on empty reported nonzero fields");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == spq_pkg::ST_FULL) |->
    (out_o.occupancy == spq_pkg::OccW'(spq_pkg::QueueDepth)))
    else $error("insert on full reported wrong occupancy");

  a_insert_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == spq_pkg::ST_INSERTED) |->
    (out_o.occupancy != '0 && out_o.out_tag == '0 && out_o.out_prio == '0))
    else $error("insert reported bad fields");

endmodule

@@ tb/tb_stable_priority_queue_top.sv @@
module tb_stable_priority_queue_top;
  import spq_pkg::*;

  localparam int ItemTotal  = 400;
  localparam int HoldCycles = 150;
  localparam int CycleLimit = 200000;
  localparam int SettleWait = 20;
  localparam int PrintCap   = 60;

  typedef struct {
    cmd_e             cmd;
    logic [PrioW-1:0] prio;
    logic [TagW-1:0]  tag;
  } access_t;

  typedef struct {
    status_e          status;
    logic [TagW-1:0]  tag;
    logic [PrioW-1:0] prio;
    logic [OccW-1:0]  occ;
  } outcome_t;

  logic clk_i;
  logic rst_ni;
  logic hold_off;

  spq_in_if  in_bus ();
  spq_out_if out_bus ();

  stable_priority_queue_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  access_t  access_queue[$];
  outcome_t expected_outcomes[$];
  entry_t   held_entries[$];

  int   total_items    = 0;
  int   accepted_count = 0;
  int   mismatch_count = 0;
  int   cycle_count    = 0;
  int   in_gap         = 0;
  int   in_quiet       = 0;
  int   out_stall      = 0;
  int   out_quiet      = 0;
  logic in_fire        = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string what);
    if (mismatch_count < PrintCap) begin
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    end
    mismatch_count++;
  endtask

  function automatic int pick_gap(inout int quiet);
    int roll;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      quiet = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Sorted insert after all entries of lower or equal priority keeps ties in
  // arrival order.
  function automatic outcome_t serve_access(access_t acc);
    outcome_t res;
    entry_t   ent;
    int       pos;
    res.status = ST_INSERTED;
    res.tag    = '0;
    res.prio   = '0;
    if (acc.cmd == CMD_INSERT) begin
      if (held_entries.size() >= QueueDepth) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_entries.size() && held_entries[pos].prio <= acc.prio) pos++;
        ent.tag  = acc.tag;
        ent.prio = acc.prio;
        held_entries.insert(pos, ent);
      end
    end else if (held_entries.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      ent        = held_entries.pop_front();
      res.status = ST_POPPED;
      res.tag    = ent.tag;
      res.prio   = ent.prio;
    end
    res.occ = OccW'(held_entries.size());
    return res;
  endfunction

  task automatic add_access(input cmd_e cmd, input int prio, input int tag);
    access_t acc;
    acc.cmd  = cmd;
    acc.prio = PrioW'(prio);
    acc.tag  = TagW'(tag);
    access_queue.push_back(acc);
  endtask

  initial begin : stimulus
    int pop_pct;
    int span;
    int narrow;
    int base;
    add_access(CMD_POP, 0, 0);
    add_access(CMD_INSERT, 15, 16'hFFFF);
    add_access(CMD_INSERT, 0, 16'h0000);
    add_access(CMD_INSERT, 7, 16'h0101);
    add_access(CMD_INSERT, 7, 16'h0202);
    add_access(CMD_INSERT, 7, 16'h0303);
    add_access(CMD_INSERT, 0, 16'h8000);
    add_access(CMD_INSERT, 15, 16'h7FFF);
    for (int k = 0; k < 9; k++) begin
      add_access(CMD_INSERT, (3 * k + 1) % 16, 16'hA5A5 ^ k);
    end
    add_access(CMD_INSERT, 0, 16'h5A5A);
    repeat (3) add_access(CMD_POP, 0, 0);

    // Random phases lean toward filling, draining or neither, so that the
    // queue reaches both full and empty many times. Narrow phases use two
    // neighboring priorities to create many ties.
    while (access_queue.size() < ItemTotal) begin
      case ($urandom_range(0, 2))
        0:       pop_pct = 15;
        1:       pop_pct = 85;
        default: pop_pct = 50;
      endcase
      span   = $urandom_range(15, 50);
      narrow = $urandom_range(0, 1);
      base   = $urandom_range(0, 14);
      repeat (span) begin
        add_access(($urandom_range(0, 99) < pop_pct) ? CMD_POP : CMD_INSERT,
                   narrow ? base + $urandom_range(0, 1) : $urandom_range(0, 15),
                   $urandom_range(0, 65535));
      end
    end
    total_items = access_queue.size();
  end

  initial begin
    rst_ni        = 1'b0;
    hold_off      = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.cmd    = CMD_INSERT;
    in_bus.prio   = '0;
    in_bus.tag    = '0;
    out_bus.ready = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(negedge clk_i) begin : drive_access
    access_t pick;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_fire) begin
      if (in_gap > 0) begin
        in_gap       <= in_gap - 1;
        in_bus.valid <= 1'b0;
      end else if (access_queue.size() > 0) begin
        pick         = access_queue.pop_front();
        in_bus.valid <= 1'b1;
        in_bus.cmd   <= pick.cmd;
        in_bus.prio  <= pick.prio;
        in_bus.tag   <= pick.tag;
        in_gap       <= pick_gap(in_quiet);
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || hold_off) begin
      out_bus.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall     <= out_stall - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
      out_stall     <= pick_gap(out_quiet);
    end
  end

  // The receiver holds off for long stretches while items keep coming, so
  // the block must stall its input.
  initial begin : receiver_hold
    int marks[2];
    marks = '{100, 280};
    foreach (marks[m]) begin
      wait (accepted_count >= marks[m]);
      @(posedge clk_i);
      hold_off = 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      hold_off = 1'b0;
    end
  end

  always @(posedge clk_i) begin : observe
    access_t  acc;
    outcome_t want;
    cycle_count++;
    in_fire = rst_ni && in_bus.valid && in_bus.ready;
    if (in_fire) begin
      acc.cmd  = cmd_e'(in_bus.cmd);
      acc.prio = in_bus.prio;
      acc.tag  = in_bus.tag;
      expected_outcomes.push_back(serve_access(acc));
      accepted_count++;
    end
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_outcomes.size() == 0) begin
        flag_mismatch("result item with no access waiting");
      end else begin
        want = expected_outcomes.pop_front();
        if (out_bus.status !== want.status) begin
          flag_mismatch($sformatf("status %0d, expected %0d", out_bus.status, want.status));
        end
        if (out_bus.out_tag !== want.tag) begin
          flag_mismatch($sformatf("out_tag %0h, expected %0h", out_bus.out_tag, want.tag));
        end
        if (out_bus.out_prio !== want.prio) begin
          flag_mismatch($sformatf("out_prio %0d, expected %0d", out_bus.out_prio, want.prio));
        end
        if (out_bus.occupancy !== want.occ) begin
          flag_mismatch($sformatf("occupancy %0d, expected %0d", out_bus.occupancy, want.occ));
        end
      end
    end
  end

  initial begin
    wait (total_items > 0 && accepted_count == total_items);
    wait (expected_outcomes.size() == 0);
    repeat (SettleWait) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Timeout after %0d cycles", cycle_count);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
